### rtl/button_gesture_classifier_top_assert.svh
// assertion macros used by the button gesture classifier core
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bgc assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define BGC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bgc assertion failed");

`endif

### rtl/bgc_pkg.sv
// types, constants and codes of the button gesture classifier
package bgc_pkg;

  localparam int unsigned NUM_INPUTS    = 4;
  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned TIME_WIDTH    = 48;
  localparam int unsigned CH_W          = 2;
  localparam int unsigned HIST_W        = $clog2(HISTORY_DEPTH);
  localparam int unsigned THR_W         = 26;
  localparam int unsigned US_PER_MS     = 1000;
  localparam int unsigned SHORT_MIN_MS  = 20;
  localparam int unsigned PENDING_MAX   = 15;
  localparam int unsigned DOUBLE_COUNT  = 2;
  localparam int unsigned EVB_DEPTH     = 4;
  localparam int unsigned EVB_W         = $clog2(EVB_DEPTH + 1);
  localparam int unsigned HCNT_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ADDR_W        = 5;

  localparam logic [THR_W-1:0] SHORT_THR = THR_W'((SHORT_MIN_MS + 1) * US_PER_MS);

  typedef enum logic [3:0] {
    EV_CLOSED = 4'd0,
    EV_OPEN   = 4'd1,
    EV_SHORT  = 4'd2,
    EV_DOUBLE = 4'd3,
    EV_LSTART = 4'd4,
    EV_LSTOP  = 4'd5,
    EV_CSTART = 4'd6,
    EV_CSTOP  = 4'd7,
    EV_TOGGLE = 4'd8
  } ev_code_e;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_ACTIVE_LOW = 3'd1,
    REG_LONG       = 3'd2,
    REG_DCW        = 3'd3,
    REG_TOG_WIN    = 3'd4,
    REG_TOG_CLICKS = 3'd5
  } reg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EDGE  = 9'b000000010,
    S_LONG  = 9'b000000100,
    S_SHORT = 9'b000001000,
    S_HIST  = 9'b000010000,
    S_TOG   = 9'b000100000,
    S_TLONG = 9'b001000000,
    S_TRES  = 9'b010000000,
    S_DRAIN = 9'b100000000
  } state_e;

  typedef struct packed {
    logic                  command;
    logic [CH_W-1:0]       channel;
    logic                  level;
    logic [TIME_WIDTH-1:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] event_channel;
    logic [3:0]      event_code;
    logic            last_event;
  } out_word_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    ev_code_e        code;
  } ev_t;

  typedef struct packed {
    logic [NUM_INPUTS-1:0] enable_mask;
    logic [NUM_INPUTS-1:0] active_low_mask;
    logic [THR_W-1:0]      long_thr;
    logic [THR_W-1:0]      dcw_thr;
    logic [THR_W-1:0]      tog_thr;
    logic [3:0]            toggle_clicks;
  } cfg_t;

endpackage

### rtl/bgc_cfg.sv
// configuration registers with apb access and precomputed time thresholds
module bgc_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output bgc_pkg::cfg_t            cfg_o
);

  logic [3:0]  enable_q, active_low_q, toggle_clicks_q;
  logic [15:0] long_q, dcw_q, tog_win_q;
  logic [bgc_pkg::THR_W-1:0] long_thr_q, dcw_thr_q, tog_thr_q;
  logic        wr_en;
  bgc_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = bgc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 4'd15;
      active_low_q    <= 4'd14;
      long_q          <= 16'd800;
      dcw_q           <= 16'd300;
      tog_win_q       <= 16'd3000;
      toggle_clicks_q <= 4'd6;
      long_thr_q      <= bgc_pkg::THR_W'(800 * bgc_pkg::US_PER_MS);
      dcw_thr_q       <= bgc_pkg::THR_W'(300 * bgc_pkg::US_PER_MS);
      tog_thr_q       <= bgc_pkg::THR_W'(3001 * bgc_pkg::US_PER_MS);
    end else if (wr_en) begin
      unique case (idx)
        bgc_pkg::REG_ENABLE:     enable_q     <= pwdata[3:0];
        bgc_pkg::REG_ACTIVE_LOW: active_low_q <= pwdata[3:0];
        bgc_pkg::REG_LONG: begin
          long_q     <= pwdata[15:0];
          long_thr_q <= bgc_pkg::THR_W'(pwdata[15:0]) *
                        bgc_pkg::THR_W'(bgc_pkg::US_PER_MS);
        end
        bgc_pkg::REG_DCW: begin
          dcw_q     <= pwdata[15:0];
          dcw_thr_q <= bgc_pkg::THR_W'(pwdata[15:0]) *
                       bgc_pkg::THR_W'(bgc_pkg::US_PER_MS);
        end
        bgc_pkg::REG_TOG_WIN: begin
          tog_win_q <= pwdata[15:0];
          tog_thr_q <= (bgc_pkg::THR_W'(pwdata[15:0]) + bgc_pkg::THR_W'(1)) *
                       bgc_pkg::THR_W'(bgc_pkg::US_PER_MS);
        end
        bgc_pkg::REG_TOG_CLICKS: toggle_clicks_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bgc_pkg::REG_ENABLE:     prdata = {28'd0, enable_q};
      bgc_pkg::REG_ACTIVE_LOW: prdata = {28'd0, active_low_q};
      bgc_pkg::REG_LONG:       prdata = {16'd0, long_q};
      bgc_pkg::REG_DCW:        prdata = {16'd0, dcw_q};
      bgc_pkg::REG_TOG_WIN:    prdata = {16'd0, tog_win_q};
      bgc_pkg::REG_TOG_CLICKS: prdata = {28'd0, toggle_clicks_q};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o.enable_mask     = enable_q;
  assign cfg_o.active_low_mask = active_low_q;
  assign cfg_o.long_thr        = long_thr_q;
  assign cfg_o.dcw_thr         = dcw_thr_q;
  assign cfg_o.tog_thr         = tog_thr_q;
  assign cfg_o.toggle_clicks   = toggle_clicks_q;

endmodule

### rtl/bgc_elapsed.sv
// shared elapsed-time unit: now - then >= threshold, zero when time runs backward
module bgc_elapsed (
  input  logic [bgc_pkg::TIME_WIDTH-1:0] now_i,
  input  logic [bgc_pkg::TIME_WIDTH-1:0] then_i,
  input  logic [bgc_pkg::THR_W-1:0]      thr_i,
  output logic                           ge_o
);

  logic [bgc_pkg::TIME_WIDTH:0] diff;

  assign diff = {1'b0, now_i} - {1'b0, then_i};
  assign ge_o = diff[bgc_pkg::TIME_WIDTH] ? (thr_i == '0) :
                (diff[bgc_pkg::TIME_WIDTH-1:0] >= bgc_pkg::TIME_WIDTH'(thr_i));

endmodule

### rtl/bgc_core.sv
// gesture sequencer: per-channel state, click history and event buffer
module bgc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bgc_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bgc_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bgc_pkg::out_word_t   out_word_o
);

  localparam int unsigned N  = bgc_pkg::NUM_INPUTS;
  localparam int unsigned HD = bgc_pkg::HISTORY_DEPTH;
  localparam int unsigned TW = bgc_pkg::TIME_WIDTH;

  bgc_pkg::state_e state_q, state_d;
  logic                      level_q, level_d;
  logic [bgc_pkg::CH_W-1:0]  cidx_q, cidx_d;
  logic [TW-1:0]             t_q, t_d;

  logic [N-1:0]  pressed_q, pressed_d, fired_q, fired_d, combo_q, combo_d;
  logic [3:0]    pend_q [N];
  logic [3:0]    pend_d [N];
  logic [TW-1:0] start_q [N];
  logic [TW-1:0] start_d [N];
  logic [TW-1:0] lshort_q [N];
  logic [TW-1:0] lshort_d [N];
  logic [TW-1:0] hist_q [N][HD];
  logic [TW-1:0] hist_d [N][HD];
  logic [bgc_pkg::HIST_W-1:0] slot_q [N];
  logic [bgc_pkg::HIST_W-1:0] slot_d [N];

  logic [bgc_pkg::HIST_W-1:0] hidx_q, hidx_d;
  logic [bgc_pkg::HCNT_W-1:0] hcnt_q, hcnt_d;

  bgc_pkg::ev_t              evb_q [bgc_pkg::EVB_DEPTH];
  bgc_pkg::ev_t              evb_d [bgc_pkg::EVB_DEPTH];
  logic [bgc_pkg::EVB_W-1:0] ev_cnt_q, ev_cnt_d, rd_q, rd_d;

  logic                out_valid_q, out_valid_d, out_load;
  bgc_pkg::out_word_t  out_q, out_d;

  logic [TW-1:0]             u_then;
  logic [bgc_pkg::THR_W-1:0] u_thr;
  logic                      u_ge;
  logic                      now_pressed, ch_en;
  bgc_pkg::ev_code_e         start_code, stop_code;

  bgc_elapsed u_elapsed (
    .now_i  (t_q),
    .then_i (u_then),
    .thr_i  (u_thr),
    .ge_o   (u_ge)
  );

  always_comb begin
    unique case (state_q)
      bgc_pkg::S_SHORT: begin u_then = start_q[cidx_q];       u_thr = bgc_pkg::SHORT_THR; end
      bgc_pkg::S_HIST:  begin u_then = hist_q[cidx_q][hidx_q]; u_thr = cfg_i.tog_thr;    end
      bgc_pkg::S_TRES:  begin u_then = lshort_q[cidx_q];      u_thr = cfg_i.dcw_thr;     end
      default:          begin u_then = start_q[cidx_q];       u_thr = cfg_i.long_thr;    end
    endcase
  end

  assign ch_en       = ({1'b0, cidx_q} < (bgc_pkg::CH_W + 1)'(N)) && cfg_i.enable_mask[cidx_q];
  assign now_pressed = cfg_i.active_low_mask[cidx_q] ? !level_q : level_q;
  assign start_code  = combo_q[cidx_q] ? bgc_pkg::EV_CSTART : bgc_pkg::EV_LSTART;
  assign stop_code   = combo_q[cidx_q] ? bgc_pkg::EV_CSTOP : bgc_pkg::EV_LSTOP;
  assign out_load    = (state_q == bgc_pkg::S_DRAIN) && (rd_q != ev_cnt_q) &&
                       (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    cidx_d      = cidx_q;
    t_d         = t_q;
    pressed_d   = pressed_q;
    fired_d     = fired_q;
    combo_d     = combo_q;
    pend_d      = pend_q;
    start_d     = start_q;
    lshort_d    = lshort_q;
    hist_d      = hist_q;
    slot_d      = slot_q;
    hidx_d      = hidx_q;
    hcnt_d      = hcnt_q;
    evb_d       = evb_q;
    ev_cnt_d    = ev_cnt_q;
    rd_d        = rd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bgc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          level_d = in_word_i.level;
          t_d     = in_word_i.time_us;
          cidx_d  = in_word_i.command ? '0 : in_word_i.channel;
          state_d = in_word_i.command ? bgc_pkg::S_TLONG : bgc_pkg::S_EDGE;
        end
      end
      bgc_pkg::S_EDGE: begin
        state_d = bgc_pkg::S_DRAIN;
        if (ch_en && now_pressed && !pressed_q[cidx_q]) begin
          pressed_d[cidx_q] = 1'b1;
          start_d[cidx_q]   = t_q;
          fired_d[cidx_q]   = 1'b0;
          combo_d[cidx_q]   = pend_q[cidx_q] != 4'd0;
          evb_d[ev_cnt_q[1:0]] = '{ch: cidx_q, code: bgc_pkg::EV_CLOSED};
          ev_cnt_d = ev_cnt_q + 1'b1;
        end else if (ch_en && !now_pressed && pressed_q[cidx_q]) begin
          pressed_d[cidx_q] = 1'b0;
          evb_d[ev_cnt_q[1:0]] = '{ch: cidx_q, code: bgc_pkg::EV_OPEN};
          if (fired_q[cidx_q]) begin
            evb_d[ev_cnt_q[1:0] + 2'd1] = '{ch: cidx_q, code: stop_code};
            ev_cnt_d = ev_cnt_q + 2'd2;
            pend_d[cidx_q]   = 4'd0;
            lshort_d[cidx_q] = '0;
            combo_d[cidx_q]  = 1'b0;
          end else begin
            ev_cnt_d = ev_cnt_q + 1'b1;
            state_d  = bgc_pkg::S_LONG;
          end
        end
      end
      bgc_pkg::S_LONG: begin
        if (u_ge) begin
          fired_d[cidx_q] = 1'b1;
          evb_d[ev_cnt_q[1:0]]        = '{ch: cidx_q, code: start_code};
          evb_d[ev_cnt_q[1:0] + 2'd1] = '{ch: cidx_q, code: stop_code};
          ev_cnt_d = ev_cnt_q + 2'd2;
          pend_d[cidx_q]   = 4'd0;
          lshort_d[cidx_q] = '0;
          combo_d[cidx_q]  = 1'b0;
          state_d = bgc_pkg::S_DRAIN;
        end else begin
          state_d = bgc_pkg::S_SHORT;
        end
      end
      bgc_pkg::S_SHORT: begin
        if (u_ge) begin
          hist_d[cidx_q][slot_q[cidx_q]] = t_q;
          slot_d[cidx_q] = (slot_q[cidx_q] == bgc_pkg::HIST_W'(HD - 1)) ? '0 :
                           slot_q[cidx_q] + 1'b1;
          hidx_d  = '0;
          hcnt_d  = '0;
          state_d = bgc_pkg::S_HIST;
        end else begin
          state_d = bgc_pkg::S_DRAIN;
        end
      end
      bgc_pkg::S_HIST: begin
        if ((hist_q[cidx_q][hidx_q] != '0) && !u_ge) begin
          hcnt_d = hcnt_q + 1'b1;
        end
        hidx_d = hidx_q + 1'b1;
        if (hidx_q == bgc_pkg::HIST_W'(HD - 1)) begin
          state_d = bgc_pkg::S_TOG;
        end
      end
      bgc_pkg::S_TOG: begin
        if (bgc_pkg::HCNT_W'(hcnt_q) >= bgc_pkg::HCNT_W'(cfg_i.toggle_clicks) &&
            {1'b0, cfg_i.toggle_clicks} <= 5'(hcnt_q)) begin
          for (int i = 0; i < HD; i++) begin
            hist_d[cidx_q][i] = '0;
          end
          pend_d[cidx_q]   = 4'd0;
          lshort_d[cidx_q] = '0;
          evb_d[ev_cnt_q[1:0]] = '{ch: cidx_q, code: bgc_pkg::EV_TOGGLE};
          ev_cnt_d = ev_cnt_q + 1'b1;
        end else begin
          if (pend_q[cidx_q] < 4'(bgc_pkg::PENDING_MAX)) begin
            pend_d[cidx_q] = pend_q[cidx_q] + 1'b1;
          end
          lshort_d[cidx_q] = t_q;
        end
        combo_d[cidx_q] = 1'b0;
        state_d = bgc_pkg::S_DRAIN;
      end
      bgc_pkg::S_TLONG: begin
        if (ch_en && pressed_q[cidx_q] && !fired_q[cidx_q] && u_ge) begin
          fired_d[cidx_q] = 1'b1;
          evb_d[ev_cnt_q[1:0]] = '{ch: cidx_q, code: start_code};
          ev_cnt_d = ev_cnt_q + 1'b1;
        end
        cidx_d = cidx_q + 1'b1;
        if (cidx_q == bgc_pkg::CH_W'(N - 1)) begin
          cidx_d  = '0;
          state_d = bgc_pkg::S_TRES;
        end
      end
      bgc_pkg::S_TRES: begin
        if (ch_en && (pend_q[cidx_q] != 4'd0) && !pressed_q[cidx_q] && u_ge) begin
          evb_d[ev_cnt_q[1:0]] = '{ch: cidx_q,
              code: (pend_q[cidx_q] == 4'(bgc_pkg::DOUBLE_COUNT)) ?
                    bgc_pkg::EV_DOUBLE : bgc_pkg::EV_SHORT};
          ev_cnt_d = ev_cnt_q + 1'b1;
          pend_d[cidx_q]   = 4'd0;
          lshort_d[cidx_q] = '0;
        end
        cidx_d = cidx_q + 1'b1;
        if (cidx_q == bgc_pkg::CH_W'(N - 1)) begin
          state_d = bgc_pkg::S_DRAIN;
        end
      end
      bgc_pkg::S_DRAIN: begin
        if (rd_q == ev_cnt_q) begin
          rd_d     = '0;
          ev_cnt_d = '0;
          state_d  = bgc_pkg::S_IDLE;
        end else if (out_load) begin
          out_d.event_channel = evb_q[rd_q[1:0]].ch;
          out_d.event_code    = evb_q[rd_q[1:0]].code;
          out_d.last_event    = (rd_q + 1'b1) == ev_cnt_q;
          out_valid_d         = 1'b1;
          rd_d                = rd_q + 1'b1;
        end
      end
      default: state_d = bgc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgc_pkg::S_IDLE;
      pressed_q   <= '0;
      fired_q     <= '0;
      combo_q     <= '0;
      ev_cnt_q    <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < N; c++) begin
        pend_q[c]   <= '0;
        start_q[c]  <= '0;
        lshort_q[c] <= '0;
        slot_q[c]   <= '0;
        for (int i = 0; i < HD; i++) begin
          hist_q[c][i] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      pressed_q   <= pressed_d;
      fired_q     <= fired_d;
      combo_q     <= combo_d;
      ev_cnt_q    <= ev_cnt_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      start_q     <= start_d;
      lshort_q    <= lshort_d;
      slot_q      <= slot_d;
      hist_q      <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    cidx_q  <= cidx_d;
    t_q     <= t_d;
    hidx_q  <= hidx_d;
    hcnt_q  <= hcnt_d;
    evb_q   <= evb_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == bgc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `include "button_gesture_classifier_top_assert.svh"

  `BGC_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_q))
  `BGC_ASSERT_IMP(a_idle_empty, state_q == bgc_pkg::S_IDLE, ev_cnt_q == '0 && rd_q == '0)
  `BGC_ASSERT_IMP(a_buf_bound, 1'b1,
                  ev_cnt_q <= bgc_pkg::EVB_W'(bgc_pkg::EVB_DEPTH) && rd_q <= ev_cnt_q)
  `BGC_ASSERT_NXT(a_load_valid, out_load, out_valid_q)

endmodule

### rtl/button_gesture_classifier_top.sv
// top level of the button gesture classifier
// usage:
//   in channel: in_valid_i/in_ready_o carry one word (command, channel, level,
//   time_us). command 0 reports a settled edge of one button channel, command 1
//   is a time tick that scans all channels for long holds and pending clicks.
//   out channel: out_valid_o/out_ready_i carry one event word per handshake;
//   last_event marks the final event caused by an input word (a word may cause
//   none). configuration through the apb port, only while the block is idle.
//   timing: in_ready_o is high only while the sequencer is idle. an edge word
//   may walk the history of eight slots, a tick makes two passes over four
//   channels, then the event buffer drains into the output register one event
//   per cycle while the receiver is ready, and the sequencer returns to idle.
//   all time compares go through one shared subtract and compare unit.
//   when the receiver stalls, draining holds and the block stays busy.
//   reset clears all channel state and click history and loads the default
//   register values.
module button_gesture_classifier_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bgc_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bgc_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  bgc_pkg::cfg_t cfg;

  bgc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

### tb/sv/button_gesture_classifier_checker.sv
// checker for the button gesture classifier: predicts events and compares output words
module button_gesture_classifier_checker
  import bgc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_word_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_word_t           out_word_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int                  err_cnt_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [3:0]  en_mask, al_mask, tog_clicks;
  logic [15:0] long_ms, dcw_ms, tog_ms;

  logic        pressed   [NUM_INPUTS];
  logic [47:0] start_t   [NUM_INPUTS];
  logic        fired     [NUM_INPUTS];
  logic        combo     [NUM_INPUTS];
  logic [3:0]  pend      [NUM_INPUTS];
  logic [47:0] last_short[NUM_INPUTS];
  logic [47:0] hist      [NUM_INPUTS][HISTORY_DEPTH];
  logic [2:0]  slot      [NUM_INPUTS];

  out_word_t   event_q[$];
  int          n_ev;
  int          errs;

  function automatic logic [47:0] ms_gap(logic [47:0] now, logic [47:0] then);
    return (now >= then) ? (now - then) / 48'd1000 : 48'd0;
  endfunction

  function void add_event(logic [1:0] c, ev_code_e code);
    out_word_t o;
    o.event_channel = c;
    o.event_code    = code;
    o.last_event    = 1'b0;
    event_q.push_back(o);
    n_ev++;
  endfunction

  function void classify_edge(logic [1:0] c, logic lvl, logic [47:0] t);
    logic        now_p;
    logic [47:0] dur;
    int          cnt;
    if (!en_mask[c]) return;
    now_p = al_mask[c] ? !lvl : lvl;
    if (now_p && !pressed[c]) begin
      pressed[c] = 1'b1;
      start_t[c] = t;
      fired[c]   = 1'b0;
      combo[c]   = pend[c] != 0;
      add_event(c, EV_CLOSED);
    end else if (!now_p && pressed[c]) begin
      dur = ms_gap(t, start_t[c]);
      pressed[c] = 1'b0;
      add_event(c, EV_OPEN);
      if (fired[c]) begin
        add_event(c, combo[c] ? EV_CSTOP : EV_LSTOP);
        pend[c] = 0;
        last_short[c] = 0;
        combo[c] = 1'b0;
      end else if (dur >= long_ms) begin
        fired[c] = 1'b1;
        add_event(c, combo[c] ? EV_CSTART : EV_LSTART);
        add_event(c, combo[c] ? EV_CSTOP : EV_LSTOP);
        pend[c] = 0;
        last_short[c] = 0;
        combo[c] = 1'b0;
      end else if (dur > SHORT_MIN_MS) begin
        hist[c][slot[c]] = t;
        slot[c] = slot[c] + 3'd1;
        cnt = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
          if (hist[c][i] != 0 && ms_gap(t, hist[c][i]) <= tog_ms) cnt++;
        if (cnt >= tog_clicks) begin
          for (int i = 0; i < HISTORY_DEPTH; i++) hist[c][i] = 0;
          pend[c] = 0;
          last_short[c] = 0;
          add_event(c, EV_TOGGLE);
        end else begin
          if (pend[c] < PENDING_MAX) pend[c] = pend[c] + 4'd1;
          last_short[c] = t;
        end
        combo[c] = 1'b0;
      end
    end
  endfunction

  function void scan_tick(logic [47:0] t);
    logic [3:0] cnt;
    for (int c = 0; c < NUM_INPUTS; c++) begin
      if (!en_mask[c] || !pressed[c] || fired[c]) continue;
      if (ms_gap(t, start_t[c]) >= long_ms) begin
        fired[c] = 1'b1;
        add_event(2'(c), combo[c] ? EV_CSTART : EV_LSTART);
      end
    end
    for (int c = 0; c < NUM_INPUTS; c++) begin
      if (!en_mask[c] || pend[c] == 0 || pressed[c]) continue;
      if (ms_gap(t, last_short[c]) < dcw_ms) continue;
      cnt = pend[c];
      pend[c] = 0;
      last_short[c] = 0;
      add_event(2'(c), cnt == DOUBLE_COUNT ? EV_DOUBLE : EV_SHORT);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      en_mask = 4'd15; al_mask = 4'd14; long_ms = 16'd800;
      dcw_ms = 16'd300; tog_ms = 16'd3000; tog_clicks = 4'd6;
      for (int c = 0; c < NUM_INPUTS; c++) begin
        pressed[c] = 0; start_t[c] = 0; fired[c] = 0; combo[c] = 0;
        pend[c] = 0; last_short[c] = 0; slot[c] = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[c][i] = 0;
      end
      event_q.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (event_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected word: ch=%0d code=%0d last=%0d",
                     out_word_i.event_channel, out_word_i.event_code,
                     out_word_i.last_event);
        end else begin
          e = event_q.pop_front();
          if (out_word_i.event_channel !== e.event_channel ||
              out_word_i.event_code !== e.event_code ||
              out_word_i.last_event !== e.last_event) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: exp ch=%0d code=%0d last=%0d, got ch=%0d code=%0d last=%0d",
                       e.event_channel, e.event_code, e.last_event,
                       out_word_i.event_channel, out_word_i.event_code,
                       out_word_i.last_event);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        n_ev = 0;
        if (in_word_i.command) scan_tick(in_word_i.time_us);
        else classify_edge(in_word_i.channel, in_word_i.level, in_word_i.time_us);
        if (n_ev > 0) event_q[$].last_event = 1'b1;
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_ENABLE:     en_mask    = pwdata_i[3:0];
          REG_ACTIVE_LOW: al_mask    = pwdata_i[3:0];
          REG_LONG:       long_ms    = pwdata_i[15:0];
          REG_DCW:        dcw_ms     = pwdata_i[15:0];
          REG_TOG_WIN:    tog_ms     = pwdata_i[15:0];
          REG_TOG_CLICKS: tog_clicks = pwdata_i[3:0];
          default: ;
        endcase
      end
      err_cnt_o <= errs;
      pending_o <= event_q.size();
    end
  end
endmodule

### tb/sv/tb_button_gesture_classifier_top.sv
// testbench top of the button gesture classifier: stimulus, configuration and verdict
module tb_button_gesture_classifier_top;
  import bgc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;

  logic              clk, rst_n;
  logic              in_valid, in_ready;
  in_word_t          in_word;
  logic              out_valid, out_ready;
  out_word_t         out_word;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  int                err_cnt, pending;

  logic [47:0] t_now;
  logic [3:0]  cur_al, cur_tc;
  logic [15:0] cur_lp, cur_dcw;
  int          items_sent;
  bit          calm;
  bit          stalled_once;
  int          idle_cnt = 0;

  button_gesture_classifier_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  button_gesture_classifier_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb_button_gesture_classifier_top NOT OK");
      $finish;
    end
  end

  // receiver with random backpressure and one long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!stalled_once && items_sent > 150) begin
        stalled_once = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic cmd, logic [1:0] ch, logic lvl, logic [47:0] t);
    in_word.command <= cmd;
    in_word.channel <= ch;
    in_word.level   <= lvl;
    in_word.time_us <= t;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic button(logic [1:0] ch, logic down);
    send_word(1'b0, ch, cur_al[ch] ? !down : down, t_now);
  endtask

  task automatic tick_now();
    send_word(1'b1, 2'($urandom), 1'($urandom), t_now);
  endtask

  task automatic adv_ms(int unsigned ms);
    t_now = t_now + 48'(ms) * 48'd1000 + 48'($urandom_range(0, 999));
  endtask

  task automatic short_click(logic [1:0] ch);
    int unsigned hi;
    hi = (cur_lp > 22) ? cur_lp - 1 : 21;
    if (hi > 400) hi = 400;
    button(ch, 1'b1);
    adv_ms($urandom_range(21, hi));
    button(ch, 1'b0);
  endtask

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] en, logic [3:0] al, logic [15:0] lp,
                            logic [15:0] dcw, logic [15:0] tw, logic [3:0] tc);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_ACTIVE_LOW, 32'(al));
    write_reg(REG_LONG, 32'(lp));
    write_reg(REG_DCW, 32'(dcw));
    write_reg(REG_TOG_WIN, 32'(tw));
    write_reg(REG_TOG_CLICKS, 32'(tc));
    cur_al = al; cur_lp = lp; cur_dcw = dcw; cur_tc = tc;
  endtask

  task automatic gesture();
    logic [1:0] ch;
    ch = 2'($urandom);
    case ($urandom_range(0, 10))
      0, 1, 2: begin
        short_click(ch);
        adv_ms($urandom_range(0, 2 * cur_dcw));
        tick_now();
      end
      3: begin
        button(ch, 1'b1);
        adv_ms(cur_lp + $urandom_range(0, 30));
        button(ch, 1'b0);
      end
      4: begin
        button(ch, 1'b1);
        adv_ms(cur_lp + $urandom_range(0, 30));
        tick_now();
        adv_ms($urandom_range(0, 50));
        button(ch, 1'b0);
        tick_now();
      end
      5: begin
        short_click(ch);
        adv_ms($urandom_range(0, cur_dcw));
        short_click(ch);
        adv_ms(cur_dcw + $urandom_range(0, 20));
        tick_now();
      end
      6: begin
        repeat (cur_tc + 1) begin
          short_click(ch);
          adv_ms($urandom_range(0, 60));
        end
        tick_now();
      end
      7: begin
        button(ch, 1'b1);
        adv_ms($urandom_range(0, 20));
        button(ch, 1'b0);
      end
      8: begin
        short_click(ch);
        adv_ms($urandom_range(0, 40));
        button(ch, 1'b1);
        adv_ms(cur_lp + $urandom_range(0, 10));
        tick_now();
        button(ch, 1'b0);
      end
      9: begin
        repeat (17) begin
          short_click(ch);
          adv_ms($urandom_range(0, 10));
        end
        adv_ms(cur_dcw);
        tick_now();
      end
      default: begin
        case ($urandom_range(0, 3))
          0: t_now = t_now - 48'($urandom_range(0, 500000));
          1: t_now = 48'({$urandom, $urandom});
          default: adv_ms($urandom_range(0, 100));
        endcase
        if ($urandom_range(0, 1)) send_word(1'b0, 2'($urandom), 1'($urandom), t_now);
        else tick_now();
        t_now = t_now & 48'h0000_7FFF_FFFF;
      end
    endcase
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_al = 4'd14; cur_lp = 16'd800; cur_dcw = 16'd300; cur_tc = 4'd6;
    items_sent = 0; calm = 1'b0; stalled_once = 1'b0;
    t_now = 48'd1000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every channel, redundant edges, ticks, time extremes and going back
    for (int c = 0; c < NUM_INPUTS; c++) begin
      button(2'(c), 1'b1);
      button(2'(c), 1'b1);
      adv_ms(100);
      button(2'(c), 1'b0);
    end
    adv_ms(400);
    tick_now();
    button(2'd0, 1'b1);
    adv_ms(900);
    tick_now();
    button(2'd0, 1'b0);
    t_now = 48'hFFFF_FFFF_FFFF;
    button(2'd1, 1'b1);
    t_now = 48'd0;
    button(2'd1, 1'b0);
    tick_now();
    t_now = 48'hFFFF_FFFF_FFFF;
    tick_now();
    t_now = 48'd5000000;
    button(2'd2, 1'b1);
    t_now = 48'd4000000;
    button(2'd2, 1'b0);
    t_now = 48'd6000000;

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(4'hF, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd8);
        1: set_config(4'hA, 4'hF, 16'd1, 16'd1, 16'd1, 4'd1);
        2: set_config(4'h0, 4'h5, 16'd500, 16'd200, 16'd2000, 4'd3);
        default: set_config(($urandom_range(0, 1)) ? 4'hF : 4'($urandom),
                            4'($urandom), 16'($urandom_range(30, 1500)),
                            16'($urandom_range(20, 600)), 16'($urandom_range(100, 5000)),
                            4'($urandom_range(1, 8)));
      endcase
      while (items_sent < (ph == 2 ? 120 : 60 + (ph + 1) * 60 - 40)) begin
        if (items_sent > 400) calm = 1'b1;
        gesture();
      end
    end
    while (items_sent < 480) begin
      calm = 1'b1;
      gesture();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_button_gesture_classifier_top OK");
    end else begin
      $display("tb_button_gesture_classifier_top NOT OK");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/bgc_pkg.sv
rtl/bgc_cfg.sv
rtl/bgc_elapsed.sv
rtl/bgc_core.sv
rtl/button_gesture_classifier_top.sv
tb/sv/button_gesture_classifier_checker.sv
tb/sv/tb_button_gesture_classifier_top.sv
